// ===== design/acfp_pkg.sv =====
`default_nettype none

package acfp_pkg;

    localparam int CMD_LEN_DEF   = 8;
    localparam int CS_DIGITS_DEF = 3;
    localparam int MAX_EMIT      = 8;

    localparam logic [7:0] CH_HEAD    = 8'h3C;
    localparam logic [7:0] CH_DELIM   = 8'h3D;
    localparam logic [7:0] CH_END     = 8'h0D;
    localparam logic [7:0] DIGIT_BASE = 8'd48;

endpackage

`default_nettype wire

// ===== design/ascii_command_frame_parser_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_rx_byte
// output    out        o_out_valid / i_out_ready   o_cmd_value, o_cmd_index, o_last
//
// Outside emission one byte beat is taken every cycle and parsed in that cycle.
// A good terminator starts emission, one store read per cycle unless the output stalls:
// each of the min(CMD_LEN, 8) beats is read from the store into a register, then loaded
// into the output register; the input is not ready until the last beat is loaded there.
// Reset is synchronous and active low and puts the parser back to hunting for the
// frame start; the command store holds no reset state.

module ascii_command_frame_parser_core #(
    parameter int CMD_LEN   = acfp_pkg::CMD_LEN_DEF,
    parameter int CS_DIGITS = acfp_pkg::CS_DIGITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_cmd_value,
    output logic      [2:0] o_cmd_index,
    output logic            o_last
);

    import acfp_pkg::*;

    localparam int EMIT_N = (CMD_LEN < MAX_EMIT) ? CMD_LEN : MAX_EMIT;
    localparam int ADDR_W = (EMIT_N > 1) ? $clog2(EMIT_N) : 1;
    localparam int BC_W   = $clog2(CMD_LEN + 1);
    localparam int CS_W   = $clog2(CS_DIGITS + 1);

    localparam logic [BC_W-1:0]   BC_FULL  = BC_W'(CMD_LEN);
    localparam logic [BC_W-1:0]   BC_STORE = BC_W'(EMIT_N);
    localparam logic [CS_W-1:0]   CS_FULL  = CS_W'(CS_DIGITS);
    localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(EMIT_N - 1);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_BODY,
        PH_DELIM,
        PH_CHECK,
        PH_END,
        PH_EMIT
    } t_phase;

    t_phase            r_phase;
    logic [BC_W-1:0]   r_body_count;
    logic [7:0]        r_body_sum;
    logic [7:0]        r_check;
    logic [CS_W-1:0]   r_digit_count;
    logic [ADDR_W-1:0] r_iss_idx;
    logic              r_iss_done;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_idx;

    logic              accept;
    logic [7:0]        value;
    logic [BC_W-1:0]   n_body_count;
    logic [7:0]        n_body_sum;
    logic [7:0]        n_check;
    logic [CS_W-1:0]   n_digit_count;
    logic              load;
    logic              issue;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign o_in_ready    = (r_phase != PH_EMIT);
    assign accept        = i_in_valid && o_in_ready;
    assign value         = i_rx_byte - DIGIT_BASE;
    assign n_body_count  = r_body_count + 1'b1;
    assign n_body_sum    = r_body_sum + value;
    assign n_check       = {r_check[4:0], 3'b000} + {r_check[6:0], 1'b0} + value;
    assign n_digit_count = r_digit_count + 1'b1;

    assign ram_we = accept && (r_phase == PH_BODY) && (i_rx_byte != CH_HEAD)
                    && (r_body_count < BC_STORE);

    assign load      = r_rd_vld && (!o_out_valid || i_out_ready);
    assign issue     = (r_phase == PH_EMIT) && !r_iss_done && (!r_rd_vld || load);
    assign ram_raddr = issue ? r_iss_idx : r_rd_idx;

    acfp_ram #(
        .WIDTH (8),
        .DEPTH (EMIT_N),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_body_count[ADDR_W-1:0]),
        .i_wdata (value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_body_count  <= '0;
            r_body_sum    <= '0;
            r_check       <= '0;
            r_digit_count <= '0;
            r_iss_done    <= 1'b0;
            r_rd_vld      <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            if (load) begin
                o_out_valid <= 1'b1;
                o_cmd_value <= ram_rdata;
                o_cmd_index <= 3'(r_rd_idx);
                o_last      <= (r_rd_idx == IDX_LAST);
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            if (r_phase == PH_EMIT) begin
                if (issue) begin
                    r_rd_idx  <= r_iss_idx;
                    r_iss_idx <= r_iss_idx + 1'b1;
                    if (r_iss_idx == IDX_LAST) begin
                        r_iss_done <= 1'b1;
                    end
                end
                r_rd_vld <= issue || (r_rd_vld && !load);
                if (load && (r_rd_idx == IDX_LAST)) begin
                    r_phase <= PH_HUNT;
                end
            end else if (accept) begin
                if ((r_phase != PH_HUNT) && (i_rx_byte == CH_HEAD)) begin
                    r_body_count <= '0;
                    r_body_sum   <= '0;
                    r_phase      <= PH_BODY;
                end else begin
                    unique case (r_phase)
                        PH_BODY: begin
                            r_body_sum   <= n_body_sum;
                            r_body_count <= n_body_count;
                            if (n_body_count == BC_FULL) begin
                                r_phase <= PH_DELIM;
                            end
                        end
                        PH_DELIM: begin
                            if (i_rx_byte == CH_DELIM) begin
                                r_check       <= '0;
                                r_digit_count <= '0;
                                r_phase       <= PH_CHECK;
                            end else begin
                                r_phase <= PH_HUNT;
                            end
                        end
                        PH_CHECK: begin
                            r_check       <= n_check;
                            r_digit_count <= n_digit_count;
                            if (n_digit_count == CS_FULL) begin
                                r_phase <= (n_check == r_body_sum) ? PH_END : PH_HUNT;
                            end
                        end
                        PH_END: begin
                            if (i_rx_byte == CH_END) begin
                                r_iss_idx  <= '0;
                                r_iss_done <= 1'b0;
                                r_rd_vld   <= 1'b0;
                                r_phase    <= PH_EMIT;
                            end else begin
                                r_phase <= PH_HUNT;
                            end
                        end
                        default: begin
                            if (i_rx_byte == CH_HEAD) begin
                                r_body_count <= '0;
                                r_body_sum   <= '0;
                                r_phase      <= PH_BODY;
                            end else begin
                                r_phase <= PH_HUNT;
                            end
                        end
                    endcase
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/acfp_ram.sv =====
`default_nettype none

module acfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acfp_pkg::*;

    localparam int CMD_LEN      = CMD_LEN_DEF;
    localparam int CS_DIGITS    = CS_DIGITS_DEF;
    localparam int EMIT_LEN     = (CMD_LEN < MAX_EMIT) ? CMD_LEN : MAX_EMIT;
    localparam int FRAME_LEN    = CMD_LEN + CS_DIGITS + 3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_STOP  = 220;

    localparam logic [2:0] PH_SEEK  = 3'd0;
    localparam logic [2:0] PH_BODY  = 3'd1;
    localparam logic [2:0] PH_DELIM = 3'd2;
    localparam logic [2:0] PH_CHECK = 3'd3;
    localparam logic [2:0] PH_TERM  = 3'd4;

    typedef struct packed {
        logic [7:0] cmd_value;
        logic [2:0] cmd_index;
        logic       last;
    } t_cmd_beat;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_cmd_value;
    logic [2:0] o_cmd_index;
    logic       o_last;

    ascii_command_frame_parser_core #(
        .CMD_LEN  (CMD_LEN),
        .CS_DIGITS(CS_DIGITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd_value(o_cmd_value),
        .o_cmd_index(o_cmd_index),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Parser state as the testbench predicts it.
    logic [2:0] rx_phase   = PH_SEEK;
    int         body_len   = 0;
    logic [7:0] cmd_store [CMD_LEN];
    logic [7:0] body_total = 8'd0;
    logic [7:0] check_acc  = 8'd0;
    int         check_len  = 0;

    t_cmd_beat  cmd_expected [$];
    logic [7:0] frame_bytes [$];

    int  items_sent      = 0;
    int  frames_accepted = 0;
    int  beats_checked   = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  rx_hold_off     = 0;
    bit  tx_idle_on      = 1'b1;
    bit  rx_idle_on      = 1'b1;

    function automatic void parse_rx_byte(input logic [7:0] b);
        logic [7:0] v;
        v = b - DIGIT_BASE;
        if (rx_phase != PH_SEEK && b == CH_HEAD) begin
            body_len   = 0;
            body_total = 8'd0;
            rx_phase   = PH_BODY;
            return;
        end
        case (rx_phase)
            PH_BODY: begin
                if (body_len < CMD_LEN) begin
                    cmd_store[body_len] = v;
                end
                body_total = body_total + v;
                body_len++;
                if (body_len >= CMD_LEN) begin
                    rx_phase = PH_DELIM;
                end
            end
            PH_DELIM: begin
                if (b == CH_DELIM) begin
                    check_acc = 8'd0;
                    check_len = 0;
                    rx_phase  = PH_CHECK;
                end else begin
                    rx_phase = PH_SEEK;
                end
            end
            PH_CHECK: begin
                check_acc = check_acc * 8'd10 + v;
                check_len++;
                if (check_len >= CS_DIGITS) begin
                    rx_phase = (check_acc == body_total) ? PH_TERM : PH_SEEK;
                end
            end
            PH_TERM: begin
                if (b == CH_END) begin
                    for (int k = 0; k < EMIT_LEN; k++) begin
                        cmd_expected.push_back(
                            t_cmd_beat'{cmd_store[k], 3'(k), k == EMIT_LEN - 1});
                    end
                    frames_accepted++;
                end
                rx_phase = PH_SEEK;
            end
            default: begin
                if (b == CH_HEAD) begin
                    body_len   = 0;
                    body_total = 8'd0;
                    rx_phase   = PH_BODY;
                end else begin
                    rx_phase = PH_SEEK;
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_body_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1) begin
            c = DIGIT_BASE + 8'($urandom_range(0, 9));
        end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_HEAD);
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_other(input logic [7:0] avoid_a,
                                              input logic [7:0] avoid_b);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == avoid_a || c == avoid_b);
        return c;
    endfunction

    // The last checksum character is solved so that the frame checks out, which
    // lets non-digit checksum characters still produce an accepted frame.
    function automatic void add_frame(input logic [7:0] body [CMD_LEN],
                                      input bit plain_digits);
        logic [7:0] total;
        logic [7:0] acc;
        logic [7:0] chars [CS_DIGITS];
        int         div;
        total = 8'd0;
        frame_bytes.push_back(CH_HEAD);
        for (int i = 0; i < CMD_LEN; i++) begin
            frame_bytes.push_back(body[i]);
            total = total + (body[i] - DIGIT_BASE);
        end
        frame_bytes.push_back(CH_DELIM);
        do begin
            acc = 8'd0;
            div = 1;
            for (int i = 1; i < CS_DIGITS; i++) begin
                div *= 10;
            end
            for (int i = 0; i < CS_DIGITS - 1; i++) begin
                chars[i] = plain_digits ? DIGIT_BASE + 8'((int'(total) / div) % 10)
                                        : pick_body_char();
                acc = acc * 8'd10 + (chars[i] - DIGIT_BASE);
                div /= 10;
            end
            chars[CS_DIGITS - 1] = total - acc * 8'd10 + DIGIT_BASE;
            plain_digits = 1'b0;
        end while (chars[CS_DIGITS - 1] == CH_HEAD);
        for (int i = 0; i < CS_DIGITS; i++) begin
            frame_bytes.push_back(chars[i]);
        end
        frame_bytes.push_back(CH_END);
    endfunction

    function automatic void add_random_frame();
        logic [7:0] body [CMD_LEN];
        for (int i = 0; i < CMD_LEN; i++) begin
            body[i] = pick_body_char();
        end
        add_frame(body, $urandom_range(0, 2) != 0);
    endfunction

    // Mostly good frames; the rest are spoiled in one of the ways the parser
    // must reject or recover from.
    function automatic void add_mixed_frame();
        int r;
        int base;
        int idx;
        int keep;
        r    = $urandom_range(0, 99);
        base = frame_bytes.size();
        add_random_frame();
        if (r < 55) begin
            return;
        end
        if (r < 63) begin
            idx = base + CMD_LEN + 1 + CS_DIGITS;
            frame_bytes[idx] = pick_other(frame_bytes[idx], CH_HEAD);
        end else if (r < 70) begin
            idx = base + CMD_LEN + 1;
            frame_bytes[idx] = pick_other(CH_DELIM, CH_HEAD);
        end else if (r < 77) begin
            idx = base + FRAME_LEN - 1;
            frame_bytes[idx] = pick_other(CH_END, CH_END);
        end else if (r < 90) begin
            keep = $urandom_range(1, FRAME_LEN - 1);
            while (frame_bytes.size() > base + keep) begin
                void'(frame_bytes.pop_back());
            end
            add_random_frame();
        end else begin
            repeat ($urandom_range(1, 4)) begin
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        parse_rx_byte(b);
        items_sent++;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_frames();
        while (frame_bytes.size() != 0) begin
            send_byte(frame_bytes.pop_front());
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cmd_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        logic [7:0] pattern [8];
        logic [7:0] body [CMD_LEN];
        pattern = '{8'h00, 8'hFF, "9", "0", 8'h80, 8'h7F, "A", " "};
        for (int i = 0; i < CMD_LEN; i++) begin
            body[i] = pattern[i % 8];
        end
        frame_bytes = '{CH_END, CH_HEAD, "1", "2"};
        add_frame(body, 1'b1);
        send_frames();
        wait_for_results();
    endtask

    task automatic test_random_frames();
        while (items_sent < RANDOM_STOP) begin
            if ($urandom_range(0, 4) == 0) begin
                tx_idle_on = !tx_idle_on;
            end
            if ($urandom_range(0, 4) == 0) begin
                rx_idle_on = !rx_idle_on;
            end
            add_mixed_frame();
            send_frames();
        end
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        tx_idle_on  = 1'b0;
        rx_hold_off = 200;
        repeat (3) add_random_frame();
        send_frames();
        wait_for_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (4) add_mixed_frame();
        send_frames();
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : out_ready_drive
        int stall;
        int r;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_off > 0) begin
                i_out_ready <= 1'b0;
                rx_hold_off--;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else if (!rx_idle_on) begin
                i_out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                i_out_ready <= (r < 70);
                if (r >= 95) begin
                    stall = $urandom_range(10, 40);
                end else if (r >= 70) begin
                    stall = $urandom_range(0, 2);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cmd_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_checked++;
            if (cmd_expected.size() == 0) begin
                $display("%0t: unexpected beat, got value %0h index %0d last %0b",
                         $time, o_cmd_value, o_cmd_index, o_last);
                mismatches++;
            end else begin
                want = cmd_expected.pop_front();
                if (o_cmd_value !== want.cmd_value) begin
                    $display("%0t: cmd_value expected %0h, got %0h",
                             $time, want.cmd_value, o_cmd_value);
                    mismatches++;
                end
                if (o_cmd_index !== want.cmd_index) begin
                    $display("%0t: cmd_index expected %0d, got %0d",
                             $time, want.cmd_index, o_cmd_index);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b, got %0b",
                             $time, want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_random_frames();
        test_output_backpressure();
        test_no_idle();
        $display("Sent %0d byte beats; %0d frames were accepted and %0d command beats checked.",
                 items_sent, frames_accepted, beats_checked);
        $display("Frames included restarts, bad delimiters, bad terminators and bad checksums.");
        if (mismatches == 0 && cmd_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== ascii_command_frame_parser_core.f =====
design/acfp_pkg.sv
design/acfp_ram.sv
design/ascii_command_frame_parser_core.sv
dv/tb.sv
